// File: hw/rtl/vslc_pkg.sv
// shared types and constants for the video sync level calibrator
package vslc_pkg;

  localparam int unsigned WINDOW_LINES_DEF = 100;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NTSC_PULSES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_PULSES  = 2'd3;

  localparam logic [2:0] PH_DISABLED   = 3'd0;
  localparam logic [2:0] PH_LINE_MIN   = 3'd1;
  localparam logic [2:0] PH_FRAME_MIN  = 3'd2;
  localparam logic [2:0] PH_LINE_MAX   = 3'd3;
  localparam logic [2:0] PH_GENERATING = 3'd4;

  localparam int unsigned IN_DATA_W = 128;
  localparam int unsigned OUT_DATA_W = 144;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic post;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

// File: hw/rtl/vslc_ctrl.sv
// sequencer for one service tick: evaluate, optional rate division, result load
module vslc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  vslc_pkg::dp_status_t  status,
  output vslc_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_POST, S_OUT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd = '0;
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.eval     = (state_r == S_EVAL);
    cmd.div_step = (state_r == S_DIV);
    cmd.post     = (state_r == S_POST);
    cmd.load_out = (state_r == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_out || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= status.need_div ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (status.div_last) state_r <= S_POST;
        end
        S_POST: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/vslc_dp.sv
// calibration state, phase step logic, rate dividers and result register
module vslc_dp #(
  parameter int unsigned WINDOW_LINES = vslc_pkg::WINDOW_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vslc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [vslc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [vslc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  vslc_pkg::ctrl_cmd_t                 cmd,
  output vslc_pkg::dp_status_t                status,
  output logic [vslc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam logic [31:0] QUARTER_LINES = 32'(WINDOW_LINES / 4);
  localparam logic [33:0] WINDOW_S = 34'(WINDOW_LINES);

  // configuration
  logic [7:0]  line_period_r;
  logic [9:0]  lines_frame_r;
  logic [6:0]  ntsc_pulses_r;
  logic [6:0]  pal_pulses_r;
  logic [31:0] line_win_r;
  logic [31:0] frame_win_r;

  // captured transaction
  logic [31:0] now_q, lines_q, frames_q, errors_q;
  logic        ntsc_q;

  // state
  logic [2:0]  phase_r;
  logic        entering_r;
  logic [31:0] deadline_r;
  logic [1:0]  fail_r;
  logic [11:0] line_level_r, fmin_r, fmax_r;
  logic [31:0] line_mark_r, calib_start_r, last_check_r, last_err_r, last_frm_r;
  logic        checking_r, camera_r, restart_r;
  logic [11:0] cmp_r, thr_r;
  logic [12:0] src_r;
  logic [31:0] cal_r, eps_r, fps_r;

  // step results
  logic [2:0]  phase_nxt;
  logic        entering_nxt;
  logic [31:0] deadline_nxt;
  logic [1:0]  fail_nxt;
  logic [11:0] line_level_nxt, fmin_nxt, fmax_nxt;
  logic [31:0] line_mark_nxt, calib_start_nxt, last_check_nxt, last_err_nxt, last_frm_nxt;
  logic        checking_nxt, camera_nxt, restart_nxt;
  logic [11:0] cmp_nxt, thr_nxt;
  logic [12:0] src_nxt;
  logic [31:0] cal_nxt;
  logic        need_div;

  // dividers
  logic [31:0] eq_r, er_r, ed_r, fq_r, fr_r, fd_r;
  logic        fneg_r, dzero_r;
  logic [4:0]  div_cnt_r;
  logic [31:0] dt, ep, fp, fp_mag, dt_mag;
  logic [32:0] e_trial, f_trial;

  assign status.need_div = need_div;
  assign status.div_last = (div_cnt_r == 5'd31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_period_r <= 8'd64;
      lines_frame_r <= 10'd625;
      ntsc_pulses_r <= 7'd12;
      pal_pulses_r  <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vslc_pkg::CFG_LINE_PERIOD: line_period_r <= cfg_data[7:0];
        vslc_pkg::CFG_LINES_FRAME: lines_frame_r <= cfg_data[9:0];
        vslc_pkg::CFG_NTSC_PULSES: ntsc_pulses_r <= cfg_data[6:0];
        vslc_pkg::CFG_PAL_PULSES:  pal_pulses_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    line_win_r  <= 32'(line_period_r) * 32'(WINDOW_LINES);
    frame_win_r <= 32'(line_period_r) * (32'(lines_frame_r) + 32'd10);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_q    <= in_tdata[31:0];
      lines_q  <= in_tdata[63:32];
      frames_q <= in_tdata[95:64];
      errors_q <= in_tdata[127:96];
      ntsc_q   <= in_tuser;
    end
  end

  function automatic logic passed(input logic [31:0] now, input logic [31:0] when);
    logic [31:0] d;
    d = now - when;
    passed = !d[31] && (d != 32'd0);
  endfunction

  assign dt     = now_q - last_check_r;
  assign ep     = 32'((errors_q - last_err_r) * 32'd1000000);
  assign fp     = 32'((frames_q - last_frm_r) * 32'd1000000);
  assign fp_mag = fp[31] ? (32'd0 - fp) : fp;
  assign dt_mag = dt[31] ? (32'd0 - dt) : dt;

  // one tick of the phase machine, apart from the rate check
  always_comb begin
    logic [31:0] dl;
    logic [33:0] seen_s, lim_s;
    logic        fin;
    logic [12:0] twice;
    logic [28:0] prod;
    logic [11:0] thr;
    phase_nxt       = phase_r;
    entering_nxt    = entering_r;
    deadline_nxt    = deadline_r;
    fail_nxt        = fail_r;
    line_level_nxt  = line_level_r;
    fmin_nxt        = fmin_r;
    fmax_nxt        = fmax_r;
    line_mark_nxt   = line_mark_r;
    calib_start_nxt = calib_start_r;
    last_check_nxt  = last_check_r;
    last_err_nxt    = last_err_r;
    last_frm_nxt    = last_frm_r;
    checking_nxt    = checking_r;
    camera_nxt      = camera_r;
    restart_nxt     = 1'b0;
    cmp_nxt         = cmp_r;
    thr_nxt         = thr_r;
    src_nxt         = src_r;
    cal_nxt         = cal_r;
    need_div        = 1'b0;
    dl              = deadline_r;
    seen_s          = '0;
    lim_s           = '0;
    fin             = 1'b0;
    twice           = '0;
    prod            = '0;
    thr             = '0;
    unique case (phase_r)
      vslc_pkg::PH_DISABLED: begin
        if (entering_r) begin
          entering_nxt = 1'b0;
          dl = now_q + 32'd250000;
          fail_nxt = fail_r + 2'd1;
        end
        deadline_nxt = dl;
        if (entering_r && (fail_nxt > 2'd1)) begin
          restart_nxt  = 1'b1;
          camera_nxt   = !camera_r;
          fail_nxt     = 2'd0;
          phase_nxt    = vslc_pkg::PH_LINE_MIN;
          entering_nxt = 1'b1;
        end else if (passed(now_q, dl)) begin
          phase_nxt    = vslc_pkg::PH_LINE_MIN;
          entering_nxt = 1'b1;
        end
      end
      vslc_pkg::PH_LINE_MIN: begin
        if (entering_r) begin
          entering_nxt    = 1'b0;
          calib_start_nxt = now_q;
          cal_nxt         = 32'd0;
          line_level_nxt  = 12'd0;
          fmin_nxt        = 12'd0;
          fmax_nxt        = 12'd0;
          line_mark_nxt   = lines_q;
          cmp_nxt         = 12'd0;
          dl = now_q + line_win_r;
        end
        deadline_nxt = dl;
        if (passed(now_q, dl)) begin
          if ((lines_q - line_mark_nxt) >= QUARTER_LINES) begin
            phase_nxt    = vslc_pkg::PH_FRAME_MIN;
            entering_nxt = 1'b1;
          end else if (line_level_nxt < 12'd2000) begin
            line_level_nxt = line_level_nxt + 12'd5;
            cmp_nxt        = line_level_nxt;
            deadline_nxt   = now_q + line_win_r;
            line_mark_nxt  = lines_q;
          end else begin
            phase_nxt    = vslc_pkg::PH_DISABLED;
            entering_nxt = 1'b1;
          end
        end
      end
      vslc_pkg::PH_FRAME_MIN: begin
        if (entering_r) begin
          entering_nxt = 1'b0;
          fmin_nxt     = line_level_r;
          dl = now_q + frame_win_r;
        end
        deadline_nxt = dl;
        if (passed(now_q, dl)) begin
          if (frames_q == 32'd0) begin
            if ((fmin_nxt < 12'd3000) && ((fmin_nxt - line_level_r) < 12'd300)) begin
              fmin_nxt     = fmin_nxt + 12'd5;
              cmp_nxt      = fmin_nxt;
              deadline_nxt = now_q + frame_win_r;
            end else begin
              phase_nxt    = vslc_pkg::PH_DISABLED;
              entering_nxt = 1'b1;
            end
          end else begin
            phase_nxt    = vslc_pkg::PH_LINE_MAX;
            entering_nxt = 1'b1;
          end
        end
      end
      vslc_pkg::PH_LINE_MAX: begin
        if (entering_r) begin
          entering_nxt  = 1'b0;
          fmax_nxt      = fmin_r + 12'd5;
          cmp_nxt       = fmax_nxt;
          dl = now_q + line_win_r;
          line_mark_nxt = lines_q;
        end
        deadline_nxt = dl;
        if (passed(now_q, dl)) begin
          seen_s = {{2{1'b0}}, lines_q - line_mark_nxt};
          seen_s = {{2{seen_s[31]}}, seen_s[31:0]};
          lim_s  = WINDOW_S - 34'(ntsc_q ? ntsc_pulses_r : pal_pulses_r);
          if ($signed(seen_s) > $signed(lim_s)) begin
            if ((fmin_r < 12'd3000) && ((fmax_nxt - fmin_r) < 12'd400)) begin
              fmax_nxt      = fmax_nxt + 12'd10;
              cmp_nxt       = fmax_nxt;
              line_mark_nxt = lines_q;
              deadline_nxt  = now_q + line_win_r;
            end else begin
              fin = 1'b1;
            end
          end else begin
            fmax_nxt = fmax_nxt - 12'd5;
            fin = 1'b1;
          end
          if (fin) begin
            twice        = {fmax_nxt - fmin_r, 1'b0};
            prod         = 29'(twice) * 29'd13108;
            thr          = fmin_r + 12'(prod[28:16]);
            thr_nxt      = thr;
            cmp_nxt      = thr;
            src_nxt      = 13'(thr) + 13'd1700;
            cal_nxt      = now_q - calib_start_r;
            phase_nxt    = vslc_pkg::PH_GENERATING;
            entering_nxt = 1'b1;
          end
        end
      end
      vslc_pkg::PH_GENERATING: begin
        if (entering_r) begin
          entering_nxt   = 1'b0;
          last_check_nxt = now_q;
          last_err_nxt   = errors_q;
          last_frm_nxt   = frames_q;
          checking_nxt   = 1'b0;
          fail_nxt       = 2'd0;
          dl = now_q + frame_win_r;
        end
        deadline_nxt = dl;
        if (passed(now_q, dl)) begin
          if (checking_nxt) begin
            need_div = 1'b1;
          end else begin
            checking_nxt   = 1'b1;
            last_check_nxt = now_q;
            last_err_nxt   = errors_q;
            last_frm_nxt   = frames_q;
            deadline_nxt   = now_q + 32'd1000000;
          end
        end
      end
      default: begin
        phase_nxt    = vslc_pkg::PH_LINE_MIN;
        entering_nxt = 1'b1;
      end
    endcase
  end

  assign e_trial = {er_r, eq_r[31]};
  assign f_trial = {fr_r, fq_r[31]};

  always_ff @(posedge clk) begin
    if (cmd.eval && need_div) begin
      eq_r      <= ep;
      er_r      <= 32'd0;
      ed_r      <= dt;
      fq_r      <= fp_mag;
      fr_r      <= 32'd0;
      fd_r      <= dt_mag;
      fneg_r    <= fp[31] ^ dt[31];
      dzero_r   <= (dt == 32'd0);
      div_cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 5'd1;
      if (e_trial >= {1'b0, ed_r}) begin
        er_r <= 32'(e_trial - {1'b0, ed_r});
        eq_r <= {eq_r[30:0], 1'b1};
      end else begin
        er_r <= e_trial[31:0];
        eq_r <= {eq_r[30:0], 1'b0};
      end
      if (f_trial >= {1'b0, fd_r}) begin
        fr_r <= 32'(f_trial - {1'b0, fd_r});
        fq_r <= {fq_r[30:0], 1'b1};
      end else begin
        fr_r <= f_trial[31:0];
        fq_r <= {fq_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] eps_v, fps_v;
    eps_v = dzero_r ? 32'hFFFF_FFFF : eq_r;
    fps_v = dzero_r ? 32'hFFFF_FFFF : (fneg_r ? (32'd0 - fq_r) : fq_r);
    if (!rst_n) begin
      phase_r       <= vslc_pkg::PH_LINE_MIN;
      entering_r    <= 1'b1;
      deadline_r    <= '0;
      fail_r        <= '0;
      line_level_r  <= '0;
      fmin_r        <= '0;
      fmax_r        <= '0;
      line_mark_r   <= '0;
      calib_start_r <= '0;
      last_check_r  <= '0;
      last_err_r    <= '0;
      last_frm_r    <= '0;
      checking_r    <= 1'b0;
      camera_r      <= 1'b0;
      restart_r     <= 1'b0;
      cmp_r         <= '0;
      thr_r         <= '0;
      src_r         <= '0;
      cal_r         <= '0;
      eps_r         <= '0;
      fps_r         <= '0;
    end else if (cmd.eval) begin
      entering_r    <= entering_nxt;
      deadline_r    <= deadline_nxt;
      fail_r        <= fail_nxt;
      line_level_r  <= line_level_nxt;
      fmin_r        <= fmin_nxt;
      fmax_r        <= fmax_nxt;
      line_mark_r   <= line_mark_nxt;
      calib_start_r <= calib_start_nxt;
      last_check_r  <= last_check_nxt;
      last_err_r    <= last_err_nxt;
      last_frm_r    <= last_frm_nxt;
      checking_r    <= checking_nxt;
      camera_r      <= camera_nxt;
      restart_r     <= restart_nxt;
      cmp_r         <= cmp_nxt;
      thr_r         <= thr_nxt;
      src_r         <= src_nxt;
      cal_r         <= cal_nxt;
      phase_r       <= phase_nxt;
    end else if (cmd.post) begin
      eps_r <= eps_v;
      fps_r <= fps_v;
      if ((eps_v > 32'd1000) || (fps_v == 32'd0)) begin
        restart_r  <= 1'b1;
        camera_r   <= !camera_r;
        phase_r    <= vslc_pkg::PH_LINE_MIN;
        entering_r <= 1'b1;
      end else begin
        last_check_r <= now_q;
        last_err_r   <= errors_q;
        last_frm_r   <= frames_q;
        deadline_r   <= now_q + 32'd1000000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {6'd0, fps_r, eps_r, cal_r, restart_r, camera_r,
                    thr_r, src_r, cmp_r, phase_r};
    end
  end

endmodule

// File: hw/rtl/video_sync_level_calibrator_core.sv
// top level of the video sync level calibrator
// One service tick is one input transaction and gives one result transaction. A tick runs
// capture, phase step and result load in that order; a tick in the generating phase whose
// once-per-second rate check falls due also runs the two 32-step radix-2 dividers that
// work out the error and frame rates side by side, and then the rate check, before its
// result load. The next tick is accepted once the current one is loaded into the result
// register, even while that result still waits to be taken. The line window is
// line_period_us times WINDOW_LINES and the frame window line_period_us times
// (lines_per_frame + 10), both in microseconds.
module video_sync_level_calibrator_core #(
  parameter int unsigned WINDOW_LINES = vslc_pkg::WINDOW_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vslc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [vslc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_us, line_total, frame_total, error_total
  input  logic [vslc_pkg::IN_DATA_W-1:0]      in_tdata,
  // is_ntsc
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // phase, comparator_mv, source_mv, threshold_mv, camera_present, restart_pulse,
  // calib_time_us, errors_per_second, frames_per_second, zero fill
  output logic [vslc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  vslc_pkg::ctrl_cmd_t  cmd;
  vslc_pkg::dp_status_t status;

  vslc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  vslc_dp #(
    .WINDOW_LINES (WINDOW_LINES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

// File: hw/rtl/vslc_checker.sv
// port-level checks for the calibrator core, bound to the top level
module vslc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vslc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while tick in progress");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= vslc_pkg::PH_GENERATING))
    else $error("phase out of range");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[41] |-> (out_tdata[2:0] == vslc_pkg::PH_LINE_MIN))
    else $error("restart without line min search");

endmodule

bind video_sync_level_calibrator_core vslc_checker u_vslc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb_video_sync_level_calibrator_core.sv
// testbench for the video sync level calibrator core
`timescale 1ns / 100ps

module tb_video_sync_level_calibrator_core;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned RANDOM_TICKS = 230;

  localparam int unsigned MODE_VIDEO = 0;
  localparam int unsigned MODE_NO_LINES = 1;
  localparam int unsigned MODE_NO_FRAMES = 2;

  typedef struct {
    logic [31:0] now_us;
    logic [31:0] line_total;
    logic [31:0] frame_total;
    logic [31:0] error_total;
    logic        is_ntsc;
  } tick_t;

  typedef struct {
    logic [2:0]  phase;
    logic [11:0] comparator_mv;
    logic [12:0] source_mv;
    logic [11:0] threshold_mv;
    logic        camera_present;
    logic        restart_pulse;
    logic [31:0] calib_time_us;
    logic [31:0] errors_per_second;
    logic [31:0] frames_per_second;
  } status_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [vslc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [vslc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [vslc_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [vslc_pkg::OUT_DATA_W-1:0] out_tdata;

  video_sync_level_calibrator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  status_t     pending_status[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // calibrator copy: registers
  logic [7:0]  line_period;
  logic [9:0]  frame_lines;
  logic [6:0]  ntsc_pulses;
  logic [6:0]  pal_pulses;
  // calibrator copy: state
  logic [2:0]  cal_phase;
  logic        cal_entry;
  logic [31:0] cal_deadline;
  logic [1:0]  cal_fails;
  logic [31:0] lvl_line;
  logic [31:0] lvl_fmin;
  logic [31:0] lvl_fmax;
  logic [31:0] cal_line_mark;
  logic [31:0] cal_start;
  logic [31:0] rate_time;
  logic [31:0] rate_errors;
  logic [31:0] rate_frames;
  logic        rate_armed;
  logic        cam_mode;
  logic [11:0] cmp_mv;
  logic [12:0] src_mv;
  logic [11:0] thr_mv;
  logic [31:0] cal_time;
  logic [31:0] err_rate;
  logic [31:0] frm_rate;

  // video source stream state
  logic [31:0] vid_now;
  logic [31:0] vid_lines;
  logic [31:0] vid_frames;
  logic [31:0] vid_errors;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic deadline_passed(logic [31:0] now, logic [31:0] when);
    logic [31:0] d;
    d = now - when;
    return $signed(d) > 0;
  endfunction

  task automatic reset_calibrator();
    line_period = 8'd64;
    frame_lines = 10'd625;
    ntsc_pulses = 7'd12;
    pal_pulses = 7'd10;
    cal_phase = vslc_pkg::PH_LINE_MIN;
    cal_entry = 1'b1;
    cal_deadline = '0;
    cal_fails = '0;
    lvl_line = '0;
    lvl_fmin = '0;
    lvl_fmax = '0;
    cal_line_mark = '0;
    cal_start = '0;
    rate_time = '0;
    rate_errors = '0;
    rate_frames = '0;
    rate_armed = 1'b0;
    cam_mode = 1'b0;
    cmp_mv = '0;
    src_mv = '0;
    thr_mv = '0;
    cal_time = '0;
    err_rate = '0;
    frm_rate = '0;
  endtask

  task automatic calibrate_tick(input tick_t t, output status_t s);
    logic [31:0] line_win;
    logic [31:0] frame_win;
    logic        restart;
    logic        skip;
    logic        final_level;
    logic [31:0] seen;
    logic [31:0] diff;
    logic [31:0] thr;
    logic [31:0] dt;
    logic [31:0] ep;
    logic [31:0] fp;
    longint      q;
    int          pulses;
    line_win = 32'(line_period) * 32'(vslc_pkg::WINDOW_LINES_DEF);
    frame_win = 32'(line_period) * (32'(frame_lines) + 32'd10);
    restart = 1'b0;
    skip = 1'b0;
    final_level = 1'b0;
    case (cal_phase)
      vslc_pkg::PH_DISABLED: begin
        if (cal_entry) begin
          cal_entry = 1'b0;
          cal_deadline = t.now_us + 32'd250000;
          cal_fails = cal_fails + 2'd1;
          if (cal_fails > 2'd1) begin
            restart = 1'b1;
            cam_mode = ~cam_mode;
            cal_fails = '0;
            cal_phase = vslc_pkg::PH_LINE_MIN;
            cal_entry = 1'b1;
            skip = 1'b1;
          end
        end
        if (!skip && deadline_passed(t.now_us, cal_deadline)) begin
          cal_phase = vslc_pkg::PH_LINE_MIN;
          cal_entry = 1'b1;
        end
      end
      vslc_pkg::PH_LINE_MIN: begin
        if (cal_entry) begin
          cal_entry = 1'b0;
          cal_start = t.now_us;
          cal_time = '0;
          lvl_line = '0;
          lvl_fmin = '0;
          lvl_fmax = '0;
          cal_line_mark = t.line_total;
          cmp_mv = '0;
          cal_deadline = t.now_us + line_win;
        end
        if (deadline_passed(t.now_us, cal_deadline)) begin
          if (t.line_total - cal_line_mark >= 32'(vslc_pkg::WINDOW_LINES_DEF / 4)) begin
            cal_phase = vslc_pkg::PH_FRAME_MIN;
            cal_entry = 1'b1;
          end else if (lvl_line < 32'd2000) begin
            lvl_line = lvl_line + 32'd5;
            cmp_mv = lvl_line[11:0];
            cal_deadline = t.now_us + line_win;
            cal_line_mark = t.line_total;
          end else begin
            cal_phase = vslc_pkg::PH_DISABLED;
            cal_entry = 1'b1;
          end
        end
      end
      vslc_pkg::PH_FRAME_MIN: begin
        if (cal_entry) begin
          cal_entry = 1'b0;
          lvl_fmin = lvl_line;
          cal_deadline = t.now_us + frame_win;
        end
        if (deadline_passed(t.now_us, cal_deadline)) begin
          if (t.frame_total != 0) begin
            cal_phase = vslc_pkg::PH_LINE_MAX;
            cal_entry = 1'b1;
          end else if (lvl_fmin < 32'd3000 && lvl_fmin - lvl_line < 32'd300) begin
            lvl_fmin = lvl_fmin + 32'd5;
            cmp_mv = lvl_fmin[11:0];
            cal_deadline = t.now_us + frame_win;
          end else begin
            cal_phase = vslc_pkg::PH_DISABLED;
            cal_entry = 1'b1;
          end
        end
      end
      vslc_pkg::PH_LINE_MAX: begin
        if (cal_entry) begin
          cal_entry = 1'b0;
          lvl_fmax = lvl_fmin + 32'd5;
          cmp_mv = lvl_fmax[11:0];
          cal_deadline = t.now_us + line_win;
          cal_line_mark = t.line_total;
        end
        if (deadline_passed(t.now_us, cal_deadline)) begin
          seen = t.line_total - cal_line_mark;
          pulses = t.is_ntsc ? int'(ntsc_pulses) : int'(pal_pulses);
          if (longint'($signed(seen)) >
              longint'(int'(vslc_pkg::WINDOW_LINES_DEF) - pulses)) begin
            if (lvl_fmin < 32'd3000 && lvl_fmax - lvl_fmin < 32'd400) begin
              lvl_fmax = lvl_fmax + 32'd10;
              cmp_mv = lvl_fmax[11:0];
              cal_line_mark = t.line_total;
              cal_deadline = t.now_us + line_win;
            end else begin
              final_level = 1'b1;
            end
          end else begin
            lvl_fmax = lvl_fmax - 32'd5;
            final_level = 1'b1;
          end
          if (final_level) begin
            diff = lvl_fmax - lvl_fmin;
            thr = lvl_fmin + (32'd2 * diff) / 32'd5;
            thr_mv = thr[11:0];
            cmp_mv = thr[11:0];
            src_mv = 13'(thr + 32'd1700);
            cal_time = t.now_us - cal_start;
            cal_phase = vslc_pkg::PH_GENERATING;
            cal_entry = 1'b1;
          end
        end
      end
      vslc_pkg::PH_GENERATING: begin
        if (cal_entry) begin
          cal_entry = 1'b0;
          rate_time = t.now_us;
          rate_errors = t.error_total;
          rate_frames = t.frame_total;
          rate_armed = 1'b0;
          cal_fails = '0;
          cal_deadline = t.now_us + frame_win;
        end
        if (deadline_passed(t.now_us, cal_deadline)) begin
          if (rate_armed) begin
            dt = t.now_us - rate_time;
            ep = (t.error_total - rate_errors) * 32'd1000000;
            fp = (t.frame_total - rate_frames) * 32'd1000000;
            if (dt == 0) begin
              err_rate = '1;
              frm_rate = '1;
            end else begin
              q = longint'($signed(fp)) / longint'($signed(dt));
              err_rate = ep / dt;
              frm_rate = q[31:0];
            end
            if (err_rate > 32'd1000 || frm_rate == 0) begin
              restart = 1'b1;
              cam_mode = ~cam_mode;
              cal_phase = vslc_pkg::PH_LINE_MIN;
              cal_entry = 1'b1;
              skip = 1'b1;
            end
          end else begin
            rate_armed = 1'b1;
          end
          if (!skip) begin
            rate_time = t.now_us;
            rate_errors = t.error_total;
            rate_frames = t.frame_total;
            cal_deadline = t.now_us + 32'd1000000;
          end
        end
      end
      default: begin
        cal_phase = vslc_pkg::PH_LINE_MIN;
        cal_entry = 1'b1;
      end
    endcase
    s.phase = cal_phase;
    s.comparator_mv = cmp_mv;
    s.source_mv = src_mv;
    s.threshold_mv = thr_mv;
    s.camera_present = cam_mode;
    s.restart_pulse = restart;
    s.calib_time_us = cal_time;
    s.errors_per_second = err_rate;
    s.frames_per_second = frm_rate;
  endtask

  task automatic send_tick(input tick_t t);
    status_t s;
    in_tvalid <= 1'b1;
    in_tdata <= {t.error_total, t.frame_total, t.line_total, t.now_us};
    in_tuser <= t.is_ntsc;
    do @(posedge clk); while (!in_tready);
    calibrate_tick(t, s);
    pending_status.push_back(s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(input logic [9:0] lp, input logic [9:0] lpf,
                                 input logic [9:0] np, input logic [9:0] pp);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= vslc_pkg::CFG_LINE_PERIOD;
    cfg_data <= lp;
    @(posedge clk);
    line_period = lp[7:0];
    cfg_idx <= vslc_pkg::CFG_LINES_FRAME;
    cfg_data <= lpf;
    @(posedge clk);
    frame_lines = lpf;
    cfg_idx <= vslc_pkg::CFG_NTSC_PULSES;
    cfg_data <= np;
    @(posedge clk);
    ntsc_pulses = np[6:0];
    cfg_idx <= vslc_pkg::CFG_PAL_PULSES;
    cfg_data <= pp;
    @(posedge clk);
    pal_pulses = pp[6:0];
    cfg_we <= 1'b0;
  endtask

  task automatic next_video_tick(input int unsigned mode, output tick_t t);
    logic [31:0] line_win;
    logic [31:0] frame_win;
    logic [31:0] span;
    logic [31:0] step;
    logic [31:0] per;
    line_win = 32'(line_period) * 32'd100;
    frame_win = 32'(line_period) * (32'(frame_lines) + 32'd10);
    per = (line_period == 0) ? 32'd1 : 32'(line_period);
    if (mode == MODE_VIDEO && $urandom_range(99) < 4) begin
      vid_now = $urandom;
      vid_lines = $urandom;
      vid_frames = $urandom;
      vid_errors = $urandom;
    end else begin
      if (cal_phase == vslc_pkg::PH_DISABLED) begin
        step = $urandom_range(50000, 300000);
      end else if (mode != MODE_VIDEO) begin
        span = (cal_phase == vslc_pkg::PH_FRAME_MIN) ? frame_win : line_win;
        step = span + $urandom_range(1, 20);
      end else begin
        span = (cal_phase == vslc_pkg::PH_GENERATING) ? 32'd400000 :
               (cal_phase == vslc_pkg::PH_FRAME_MIN) ? frame_win : line_win;
        step = $urandom_range(1, span + span / 2 + 2);
      end
      vid_now = vid_now + step;
      if (mode != MODE_NO_LINES && (mode != MODE_VIDEO || $urandom_range(99) >= 20))
        vid_lines = vid_lines + (step / per) * $urandom_range(5, 12) / 10;
      if (mode == MODE_NO_FRAMES || $urandom_range(99) < 8)
        vid_frames = '0;
      else if ($urandom_range(99) < 85)
        vid_frames = vid_frames + $urandom_range(1, 3);
      if ($urandom_range(99) < 5)
        vid_errors = vid_errors + $urandom_range(1000, 100000);
      else
        vid_errors = vid_errors + $urandom_range(0, 200);
    end
    t.now_us = vid_now;
    t.line_total = vid_lines;
    t.frame_total = vid_frames;
    t.error_total = vid_errors;
    t.is_ntsc = $urandom_range(1);
  endtask

  task automatic test_directed();
    tick_t t;
    t = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
    send_tick(t);
    t = '{'1, '1, '1, '1, 1'b1};
    send_tick(t);
    t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0};
    send_tick(t);
    t = '{32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 1'b1};
    send_tick(t);
    vid_now = 32'd0;
    vid_lines = 32'd0;
    vid_frames = 32'd0;
    vid_errors = 32'd0;
    for (int i = 0; i < 20; i++) begin
      vid_now = vid_now + 32'd7000;
      vid_lines = vid_lines + 32'd110;
      if (i > 4)
        vid_frames = vid_frames + 32'd1;
      t = '{vid_now, vid_lines, vid_frames, vid_errors, 1'(i)};
      send_tick(t);
    end
  endtask

  task automatic test_signal_loss();
    tick_t t;
    write_registers(10'd1, 10'd1, 10'h3ff, 10'd0);
    for (int i = 0; i < 420; i++) begin
      next_video_tick(MODE_NO_LINES, t);
      send_tick(t);
    end
    for (int i = 0; i < 100; i++) begin
      next_video_tick(MODE_NO_FRAMES, t);
      send_tick(t);
    end
  endtask

  task automatic test_random_video(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [9:0] lp, input logic [9:0] lpf,
                                   input logic [9:0] np, input logic [9:0] pp);
    tick_t t;
    write_registers(lp, lpf, np, pp);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_TICKS; i++) begin
      next_video_tick(MODE_VIDEO, t);
      send_tick(t);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tready) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.phase = out_tdata[2:0];
      got.comparator_mv = out_tdata[14:3];
      got.source_mv = out_tdata[27:15];
      got.threshold_mv = out_tdata[39:28];
      got.camera_present = out_tdata[40];
      got.restart_pulse = out_tdata[41];
      got.calib_time_us = out_tdata[73:42];
      got.errors_per_second = out_tdata[105:74];
      got.frames_per_second = out_tdata[137:106];
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_status.pop_front();
        if (got.phase !== want.phase || got.comparator_mv !== want.comparator_mv ||
            got.source_mv !== want.source_mv || got.threshold_mv !== want.threshold_mv ||
            got.camera_present !== want.camera_present ||
            got.restart_pulse !== want.restart_pulse ||
            got.calib_time_us !== want.calib_time_us ||
            got.errors_per_second !== want.errors_per_second ||
            got.frames_per_second !== want.frames_per_second) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    out_tready <= 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reset_calibrator();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_signal_loss();
    test_random_video(0, 0, 10'd1, 10'd1023, 10'd0, 10'd99);
    test_random_video(54, 0, 10'd255, 10'd1, 10'd99, 10'd0);
    test_random_video(0, 54, 10'd0, 10'd0, 10'h3ff, 10'd12);
    test_random_video(31, 31, 10'd64, 10'd625, 10'd12, 10'd10);
    test_random_video(0, 0, 10'h3ff, 10'h3ff, 10'd50, 10'h3ff);
    drain_results();
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
